>>> rtl/core/arf_pkg.sv
// Shared types and constants for the AT response line framer.
// No dependencies; compile first.
package arf_pkg;

    localparam int LINE_DEPTH = 63;
    localparam int CNT_W      = $clog2(LINE_DEPTH + 1);

    typedef logic [7:0]       t_byte;
    typedef logic [CNT_W-1:0] t_cnt;

    localparam t_cnt  FILL_MAX = t_cnt'(LINE_DEPTH);

    localparam t_byte CHAR_NL = 8'h0A;
    localparam t_byte CHAR_O  = 8'h4F;
    localparam t_byte CHAR_K  = 8'h4B;
    localparam t_byte CHAR_E  = 8'h45;
    localparam t_byte CHAR_R  = 8'h52;
    localparam t_byte CHAR_F  = 8'h46;
    localparam t_byte CHAR_A  = 8'h41;
    localparam t_byte CHAR_I  = 8'h49;
    localparam t_byte CHAR_L  = 8'h4C;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_LOAD,
        S_NL
    } t_state;

    typedef struct packed {
        logic accept_en;
        logic load_byte;
        logic load_nl;
    } t_cmd;

    typedef struct packed {
        logic hit_fire;
        logic rd_done;
        logic out_free;
    } t_status;

endpackage

>>> rtl/core/arf_if.sv
// Valid/ready channel interfaces for received bytes and framed output words.
// Depends on arf_pkg.
interface arf_rx_if import arf_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte rx_byte;

    modport source(output valid, output rx_byte, input ready);
    modport sink(input valid, input rx_byte, output ready);
endinterface

interface arf_tx_if import arf_pkg::*;;
    logic  valid;
    logic  ready;
    t_byte out_byte;
    logic  line_end;
    logic  truncated;

    modport source(output valid, output out_byte, output line_end, output truncated,
                   input ready);
    modport sink(input valid, input out_byte, input line_end, input truncated,
                 output ready);
endinterface

>>> rtl/core/at_response_line_framer_top.sv
// A non-terminating byte is taken and yields no word.
// Throughput: one received byte per cycle while a line collects. A terminator
// starts readout: each buffered word passes a read state (memory read port,
// registered read) and then a load state, which waits for a free output; then
// the newline; fill+1 words for a fill of up to 63. Bytes are refused until the newline is loaded.
// Reset: synchronous active low; clears fill count, history, flags and state.
module at_response_line_framer_top import arf_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    arf_rx_if.sink   i_rx,
    arf_tx_if.source o_tx
);

    t_cmd    cmd;
    t_status status;

    // Controller sequences intake and readout; it never touches payload.
    arf_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_cmd    (cmd)
    );

    // Datapath holds the line buffer, the four-byte match history and the
    // output register, so a finished word can wait while intake goes on.
    arf_datapath u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_rx     (i_rx),
        .o_tx     (o_tx)
    );

`ifndef SYNTHESIS
    // Hold off intake once a terminator has been taken.
    a_stop_after_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        status.hit_fire |=> !i_rx.ready)
        else $error("byte intake continued after a terminator");

    // Loading the newline presents a marked last word next cycle.
    a_nl_marked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.load_nl |=> (o_tx.valid && o_tx.line_end && o_tx.out_byte == CHAR_NL))
        else $error("newline word not presented with line end");

    // Buffered words only appear during readout, while intake is held.
    a_data_in_readout: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_tx.valid && !o_tx.line_end) |-> !i_rx.ready)
        else $error("buffered word shown outside readout");
`endif

endmodule

>>> rtl/core/arf_ctrl.sv
// Controller state machine: byte intake, buffer readout, newline append.
// Depends on arf_pkg.
module arf_ctrl import arf_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_cmd    o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_status.hit_fire) n_state = S_READ;
            end
            S_READ: begin
                n_state = i_status.rd_done ? S_NL : S_LOAD;
            end
            S_LOAD: begin
                if (i_status.out_free) n_state = S_READ;
            end
            S_NL: begin
                if (i_status.out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_IDLE:  o_cmd.accept_en = 1'b1;
            S_LOAD:  o_cmd.load_byte = i_status.out_free;
            S_NL:    o_cmd.load_nl   = i_status.out_free;
            S_READ:  o_cmd           = '0;
            default: o_cmd           = '0;
        endcase
    end

endmodule

>>> rtl/core/arf_datapath.sv
// Datapath: line buffer memory, fill count, match history and output register.
// Depends on arf_pkg and the channel interfaces in arf_if.sv.
module arf_datapath import arf_pkg::*; (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  t_cmd           i_cmd,
    output t_status        o_status,
    arf_rx_if.sink         i_rx,
    arf_tx_if.source       o_tx
);

    t_byte       r_mem [0:LINE_DEPTH-1];
    t_cnt        r_fill;
    t_cnt        n_fill;
    logic [31:0] r_recent;
    logic [31:0] n_recent;
    logic        r_dropped;
    logic        n_dropped;
    t_cnt        r_rd_idx;
    t_cnt        n_rd_idx;
    t_byte       r_rd_data;
    logic        r_out_valid;
    logic        n_out_valid;
    t_byte       r_out_byte;
    logic        r_out_end;
    logic        r_out_trunc;

    logic  fire;
    logic  store_ok;
    logic  match;
    t_byte cur;
    t_byte h1, h2, h3, h4;

    assign fire     = i_cmd.accept_en & i_rx.valid;
    assign store_ok = (r_fill < FILL_MAX);
    assign cur      = i_rx.rx_byte;
    assign h1       = r_recent[7:0];
    assign h2       = r_recent[15:8];
    assign h3       = r_recent[23:16];
    assign h4       = r_recent[31:24];

    // Terminators: newline-O-K, E-R-R-O-R, F-A-I-L.
    assign match = (cur == CHAR_K && h1 == CHAR_O && h2 == CHAR_NL)
                || (cur == CHAR_R && h1 == CHAR_O && h2 == CHAR_R && h3 == CHAR_R
                    && h4 == CHAR_E)
                || (cur == CHAR_L && h1 == CHAR_I && h2 == CHAR_A && h3 == CHAR_F);

    assign o_status.hit_fire = fire & match;
    assign o_status.rd_done  = (r_rd_idx == r_fill);
    assign o_status.out_free = ~r_out_valid | o_tx.ready;

    assign i_rx.ready     = i_cmd.accept_en;
    assign o_tx.valid     = r_out_valid;
    assign o_tx.out_byte  = r_out_byte;
    assign o_tx.line_end  = r_out_end;
    assign o_tx.truncated = r_out_trunc;

    always_ff @(posedge i_clk) begin
        if (fire && store_ok) begin
            r_mem[r_fill] <= cur;
        end
        if (r_rd_idx < FILL_MAX) begin
            r_rd_data <= r_mem[r_rd_idx];
        end
    end

    always_comb begin
        n_fill      = r_fill;
        n_recent    = r_recent;
        n_dropped   = r_dropped;
        n_rd_idx    = r_rd_idx;
        n_out_valid = r_out_valid;
        if (fire) begin
            if (store_ok) n_fill = r_fill + t_cnt'(1);
            else          n_dropped = 1'b1;
            n_recent = {r_recent[23:0], cur};
            n_rd_idx = '0;
        end
        if (o_tx.ready) n_out_valid = 1'b0;
        if (i_cmd.load_byte) begin
            n_out_valid = 1'b1;
            n_rd_idx    = r_rd_idx + t_cnt'(1);
        end
        if (i_cmd.load_nl) begin
            n_out_valid = 1'b1;
            n_fill      = '0;
            n_recent    = '0;
            n_dropped   = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_recent    <= '0;
            r_dropped   <= 1'b0;
            r_rd_idx    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill      <= n_fill;
            r_recent    <= n_recent;
            r_dropped   <= n_dropped;
            r_rd_idx    <= n_rd_idx;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_byte) begin
            r_out_byte  <= r_rd_data;
            r_out_end   <= 1'b0;
            r_out_trunc <= r_dropped;
        end else if (i_cmd.load_nl) begin
            r_out_byte  <= CHAR_NL;
            r_out_end   <= 1'b1;
            r_out_trunc <= r_dropped;
        end
    end

endmodule
